// ----- hw/rtl/sliding_window_event_rate_assert.svh -----
// Assertion macros for the sliding window event rate meter.
// Define NO_ASSERTIONS to compile them out.
`ifndef SLIDING_WINDOW_EVENT_RATE_ASSERT_SVH
`define SLIDING_WINDOW_EVENT_RATE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising edge outside reset.
`define SWER_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sliding_window_event_rate: assertion failed");

// Next-cycle implication.
`define SWER_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sliding_window_event_rate: assertion failed");

`else

`define SWER_ASSERT_NOW(label, ante, cons)
`define SWER_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- hw/rtl/swer_pkg.sv -----
package swer_pkg;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_SET    = 2'd2;

  localparam int unsigned TIME_W   = 48;
  localparam int unsigned RATE_W   = 32;
  localparam int unsigned WIN_W    = 16;
  localparam int unsigned LIVE_W   = 9;
  // (window_ms + 1) * 1000 peaks at 65,536,000
  localparam int unsigned THR_W    = 26;

  localparam logic [9:0] RATE_SCALE = 10'd1000;

  typedef struct packed {
    logic [1:0]        op;
    logic [TIME_W-1:0] time_us;
    logic [RATE_W-1:0] set_value;
  } swer_in_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [LIVE_W-1:0] live_count;
    logic              dropped;
  } swer_out_t;

  typedef struct packed {
    logic load;
    logic pop;
    logic store;
    logic div_start;
    logic div_step;
    logic rate_update;
    logic set_rate;
  } swer_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       expired;
    logic       div_last;
  } swer_stat_t;

endpackage

// ----- hw/rtl/swer_dp.sv -----
module swer_dp #(
  parameter int RING_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [swer_pkg::WIN_W-1:0]     cfg_wdata,
  input  swer_pkg::swer_in_t             item,
  input  swer_pkg::swer_cmd_t            cmd,
  output swer_pkg::swer_stat_t           stat,
  output swer_pkg::swer_out_t            result
);
  import swer_pkg::*;

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int NUM_W = $clog2(RING_DEPTH * 1000 + 1);
  localparam int DCNT_W = $clog2(NUM_W);

  logic [TIME_W-1:0] ring [RING_DEPTH];
  logic [TIME_W-1:0] rd_data;

  logic [WIN_W-1:0]  window_ms;
  logic [1:0]        op;
  logic [TIME_W-1:0] now;
  logic [RATE_W-1:0] set_value;
  logic [THR_W-1:0]  thr;

  logic [PTR_W-1:0]  newest_ptr;
  logic [PTR_W-1:0]  oldest_ptr;
  logic [CNT_W-1:0]  stamp_count;
  logic [RATE_W-1:0] held_rate;
  logic              dropped;

  logic [NUM_W-1:0]  quo;
  logic [WIN_W-1:0]  rem;
  logic [DCNT_W-1:0] div_cnt;

  logic [TIME_W:0]   diff;
  logic              full;
  logic [WIN_W:0]    shifted;
  logic              fits;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full = (stamp_count == CNT_W'(RING_DEPTH));
  assign diff = {1'b0, now} - {1'b0, rd_data};
  // Age in whole ms exceeds the window exactly when age_us >= (window + 1) * 1000.
  assign stat.expired  = (stamp_count != '0) && !diff[TIME_W] &&
                         (diff[TIME_W-1:0] >= TIME_W'(thr));
  assign stat.op       = op;
  assign stat.div_last = (div_cnt == '0);

  assign shifted = {rem, quo[NUM_W-1]};
  assign fits    = (shifted >= {1'b0, window_ms});

  // Ring storage, registered read at the oldest slot.
  always_ff @(posedge clk) begin
    if (cmd.store && !full) begin
      ring[newest_ptr] <= now;
    end
    rd_data <= ring[oldest_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms <= WIN_W'(1000);
    end else if (cfg_we) begin
      window_ms <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op        <= item.op;
      now       <= item.time_us;
      set_value <= item.set_value;
      thr       <= THR_W'({1'b0, window_ms} + 17'd1) * THR_W'(RATE_SCALE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      newest_ptr  <= '0;
      oldest_ptr  <= '0;
      stamp_count <= '0;
      held_rate   <= '0;
      dropped     <= 1'b0;
    end else begin
      if (cmd.load) begin
        dropped <= 1'b0;
      end
      if (cmd.pop) begin
        oldest_ptr  <= next_slot(oldest_ptr);
        stamp_count <= stamp_count - 1'b1;
      end
      if (cmd.store) begin
        if (full) begin
          dropped <= 1'b1;
        end else begin
          newest_ptr  <= next_slot(newest_ptr);
          stamp_count <= stamp_count + 1'b1;
        end
      end
      if (cmd.set_rate) begin
        held_rate <= set_value;
      end
      if (cmd.rate_update) begin
        if (window_ms == '0) begin
          held_rate <= (stamp_count != '0) ? '1 : '0;
        end else begin
          held_rate <= RATE_W'(quo);
        end
      end
    end
  end

  // Restoring divider, one quotient bit a cycle.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo     <= NUM_W'(stamp_count) * NUM_W'(RATE_SCALE);
      rem     <= '0;
      div_cnt <= DCNT_W'(NUM_W - 1);
    end else if (cmd.div_step) begin
      quo     <= {quo[NUM_W-2:0], fits};
      rem     <= fits ? WIN_W'(shifted - {1'b0, window_ms}) : shifted[WIN_W-1:0];
      div_cnt <= div_cnt - 1'b1;
    end
  end

  assign result.rate       = held_rate;
  assign result.live_count = LIVE_W'(stamp_count);
  assign result.dropped    = dropped;

endmodule

// ----- hw/rtl/swer_ctrl.sv -----
module swer_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  swer_pkg::swer_stat_t stat,
  output swer_pkg::swer_cmd_t  cmd,
  output logic                 busy,
  output logic                 done
);
  import swer_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_STORE = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_RATE  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        priority if (stat.op == OP_TICK || stat.op == OP_UPDATE) begin
          state_next = S_CHK;
        end else if (stat.op == OP_SET) begin
          cmd.set_rate = 1'b1;
          state_next   = S_DONE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CHK: begin
        priority if (stat.expired) begin
          cmd.pop    = 1'b1;
          state_next = S_WAIT;
        end else if (stat.op == OP_TICK) begin
          state_next = S_STORE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_WAIT: begin
        state_next = S_CHK;
      end
      S_STORE: begin
        cmd.store  = 1'b1;
        state_next = S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_RATE;
        end
      end
      S_RATE: begin
        cmd.rate_update = 1'b1;
        state_next      = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

// ----- hw/rtl/sliding_window_event_rate.sv -----
// Sequence: set and ignored ops load, dispatch and finish; tick and update walk expiry,
//   then tick stores; update divides, clog2(RING_DEPTH*1000+1) quotient bits (18 at 256).
// Throughput: one item at a time; expiry walk and the bit-serial divider set the time.
// Reset (rst, synchronous): ring empty, held rate 0, window_ms 1000, controller idle.
// done is a one-cycle strobe; the receiver cannot stall it.
`include "sliding_window_event_rate_assert.svh"

module sliding_window_event_rate #(
  parameter int RING_DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  swer_pkg::swer_in_t          item,
  output logic                        done,
  output swer_pkg::swer_out_t         result,
  input  logic                        cfg_we,
  input  logic [swer_pkg::WIN_W-1:0]  cfg_wdata
);
  import swer_pkg::*;

  // live_count as it reads when the ring is full (truncated to the port width)
  localparam logic [LIVE_W-1:0] FULL_LIVE = LIVE_W'(RING_DEPTH);

  swer_cmd_t  cmd;
  swer_stat_t stat;

  // Controller: accepts an item, walks expiry (read oldest, compare, pop) for a tick or
  // update, then stores a tick or runs the divider; a set loads the rate; then strobes done.
  swer_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Datapath: timestamp ring memory, pointers and count, window register,
  // expiry threshold, restoring divider and the held rate.
  swer_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

  // An accepted item always keeps the block busy in the next cycle.
  `SWER_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // done lasts one cycle and the block is idle right after it.
  `SWER_ASSERT_NEXT(a_done_pulse, done, !done && !busy)
  // A result is only reported while the item is still held.
  `SWER_ASSERT_NOW(a_done_busy, done, busy)
  // A drop happens only with a full ring.
  `SWER_ASSERT_NOW(a_drop_full, done && result.dropped, result.live_count == FULL_LIVE)

endmodule
